FILE: sv/ckum_pkg.sv
package ckum_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int EH_W       = $clog2(MAX_HEIGHT + 1);

    // Register and field widths
    localparam int GAIN_W     = 9;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CH_N       = 3;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Sharpen arithmetic widths
    localparam int FRAC_W     = 10;
    localparam int SUM_W      = CH_W + 2;
    localparam int DIFF_W     = CH_W + 3;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int ACC_W      = PROD_W + 1;

    typedef logic [COL_W-1:0]      t_col;
    typedef logic [EW_W-1:0]       t_ew;
    typedef logic [PEND_W-1:0]     t_pend;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic [EH_W-1:0]       t_eh;
    typedef logic [GAIN_W-1:0]     t_gain;
    typedef logic [FW_W-1:0]       t_fw;
    typedef logic [FH_W-1:0]       t_fh;
    typedef logic [CH_W-1:0]       t_chan;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [1:0]            t_src;

    typedef logic [SUM_W-1:0]         t_sum;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Pixel: channel 0 red, 1 green, 2 blue
    typedef logic [CH_N-1:0][CH_W-1:0] t_rgb;

    // Cross neighbourhood of one output pixel
    typedef struct packed {
        t_rgb up;
        t_rgb left;
        t_rgb center;
        t_rgb right;
        t_rgb down;
    } t_win;

    // Register indexes
    localparam t_cfg_idx CFG_GAIN   = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    // Register reset values
    localparam t_gain GAIN_RESET = 9'd0;
    localparam t_fw   FW_RESET   = 12'd2048;
    localparam t_fh   FH_RESET   = 13'd1;

    // Item operations
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Source of the centre pixel in the compute stage
    localparam t_src SRC_WIN  = 2'd0;
    localparam t_src SRC_RD   = 2'd1;
    localparam t_src SRC_HOLD = 2'd2;

endpackage

FILE: sv/ckum_if.sv
interface ckum_pix_if;
    logic              valid;
    logic              ready;
    logic              operation;
    ckum_pkg::t_chan   in_red;
    ckum_pkg::t_chan   in_green;
    ckum_pkg::t_chan   in_blue;

    modport source (output valid, output operation, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input operation, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

interface ckum_res_if;
    logic              valid;
    logic              ready;
    ckum_pkg::t_chan   out_red;
    ckum_pkg::t_chan   out_green;
    ckum_pkg::t_chan   out_blue;
    logic              frame_done;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_done, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_done, output ready);
endinterface

interface ckum_cfg_if;
    logic                 valid;
    logic                 ready;
    ckum_pkg::t_cfg_idx   index;
    ckum_pkg::t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/cross_kernel_unsharp_mask.sv
// Cross-kernel unsharp mask for an RGB raster stream. Pixel words arrive in raster order;
// each output pixel leaves with the pixel word that comes frame_width+1 pixel words after its
// own, so the tail of a frame is pushed out by the next frame or flushed by drain words,
// which emit one pending pixel each once a frame is complete and do nothing otherwise.
// Inner pixels get centre + (centre - mean of the four cross neighbours) * gain_q8 / 256 per
// channel, truncated and clamped to 0..255; pixels in the first or last row or column pass
// through unchanged, and frame_done marks the bottom right pixel. One word is taken every
// clock while the result side does not stall: the line stores are read in the accept cycle,
// and the sharpen multiply sits between the window register and the output register, which
// a result passes in turn after the word that releases it. The two 2048 x 24 line stores
// need no clearing after reset. Writing frame_width or frame_height restarts the stream and
// drops pending pixels; configure only while the block is idle.
module cross_kernel_unsharp_mask (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckum_pix_if.sink   i_pix,
    ckum_res_if.source o_res,
    ckum_cfg_if.sink   i_cfg
);

    // Configuration registers
    ckum_pkg::t_gain r_gain;
    ckum_pkg::t_fw   r_fw;
    ckum_pkg::t_fh   r_fh;

    // Stream position state
    ckum_pkg::t_col  r_col, n_col;
    ckum_pkg::t_row  r_row, n_row;
    ckum_pkg::t_pend r_pend, n_pend;
    ckum_pkg::t_col  r_ocol, n_ocol;
    ckum_pkg::t_row  r_orow, n_orow;

    // Window and line store taps
    ckum_pkg::t_rgb  r_last, r_dn, r_c, r_l, r_up;
    ckum_pkg::t_col  r_prev_col;
    logic            r_a_fresh;
    ckum_pkg::t_rgb  r_a_hold;
    ckum_pkg::t_rgb  a_val;
    ckum_pkg::t_rgb  ram1_rd, ram2_rd;

    // Compute stage and output register
    logic            r_s1_valid;
    logic            r_s1_inner;
    logic            r_s1_done;
    ckum_pkg::t_src  r_s1_src;
    logic            r_o_valid;
    ckum_pkg::t_rgb  r_o_px;
    logic            r_o_done;

    ckum_pkg::t_ew   w_eff;
    ckum_pkg::t_eh   h_eff;
    ckum_pkg::t_pend w_plus1;
    ckum_pkg::t_rgb  in_px;
    ckum_pkg::t_col  drain_addr;
    ckum_pkg::t_win  s1_win;
    ckum_pkg::t_rgb  s1_px;

    logic cfg_take, restart;
    logic pix_acc, pix_take, drn_take;
    logic pend_full, at_start, pix_emit, drn_emit, emit;
    logic col_last, row_last, ocol_last, orow_last;
    logic out_inner, out_done;
    logic s1_adv;
    logic ram1_rd_en;
    ckum_pkg::t_col ram1_rd_addr;

    // Clamp geometry
    always_comb begin
        if (r_fw == '0) begin
            w_eff = ckum_pkg::t_ew'(1);
        end else if (32'(r_fw) > ckum_pkg::MAX_WIDTH) begin
            w_eff = ckum_pkg::t_ew'(ckum_pkg::MAX_WIDTH);
        end else begin
            w_eff = ckum_pkg::t_ew'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = ckum_pkg::t_eh'(1);
        end else if (32'(r_fh) > ckum_pkg::MAX_HEIGHT) begin
            h_eff = ckum_pkg::t_eh'(ckum_pkg::MAX_HEIGHT);
        end else begin
            h_eff = ckum_pkg::t_eh'(r_fh);
        end
    end

    // Configuration writes
    assign i_cfg.ready = 1'b1;
    assign cfg_take    = i_cfg.valid & i_cfg.ready;
    assign restart     = cfg_take & ((i_cfg.index == ckum_pkg::CFG_WIDTH) ||
                                     (i_cfg.index == ckum_pkg::CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= ckum_pkg::GAIN_RESET;
            r_fw   <= ckum_pkg::FW_RESET;
            r_fh   <= ckum_pkg::FH_RESET;
        end else if (cfg_take) begin
            case (i_cfg.index)
                ckum_pkg::CFG_GAIN:   r_gain <= i_cfg.data[ckum_pkg::GAIN_W-1:0];
                ckum_pkg::CFG_WIDTH:  r_fw   <= i_cfg.data[ckum_pkg::FW_W-1:0];
                ckum_pkg::CFG_HEIGHT: r_fh   <= i_cfg.data[ckum_pkg::FH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake: take a word whenever the compute stage is free or moving on
    assign s1_adv      = r_s1_valid & (~r_o_valid | o_res.ready);
    assign i_pix.ready = ~r_s1_valid | s1_adv;
    assign pix_acc     = i_pix.valid & i_pix.ready;
    assign pix_take    = pix_acc & (i_pix.operation == ckum_pkg::OP_PIXEL);
    assign drn_take    = pix_acc & (i_pix.operation == ckum_pkg::OP_DRAIN);
    assign in_px       = {i_pix.in_blue, i_pix.in_green, i_pix.in_red};

    // Decide whether this word releases a pixel
    assign w_plus1   = ckum_pkg::t_pend'(w_eff) + ckum_pkg::t_pend'(1);
    assign pend_full = (r_pend == w_plus1);
    assign at_start  = (r_col == '0) && (r_row == '0);
    assign pix_emit  = pix_take & pend_full;
    assign drn_emit  = drn_take & at_start & (r_pend != '0);
    assign emit      = pix_emit | drn_emit;

    // Position wrap tests
    assign col_last  = (ckum_pkg::t_ew'(r_col) + ckum_pkg::t_ew'(1)) >= w_eff;
    assign row_last  = (ckum_pkg::t_eh'(r_row) + ckum_pkg::t_eh'(1)) >= h_eff;
    assign ocol_last = (ckum_pkg::t_ew'(r_ocol) + ckum_pkg::t_ew'(1)) >= w_eff;
    assign orow_last = (ckum_pkg::t_eh'(r_orow) + ckum_pkg::t_eh'(1)) >= h_eff;
    assign out_inner = (r_orow != '0) && ~orow_last && (r_ocol != '0) && ~ocol_last;
    assign out_done  = ((ckum_pkg::t_eh'(r_orow) + ckum_pkg::t_eh'(1)) == h_eff) &&
                       ((ckum_pkg::t_ew'(r_ocol) + ckum_pkg::t_ew'(1)) == w_eff);

    // Advance input and output positions and the pending count
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (pix_take) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ckum_pkg::t_row'(1);
            end else begin
                n_col = r_col + ckum_pkg::t_col'(1);
            end
            if (!pend_full) begin
                n_pend = r_pend + ckum_pkg::t_pend'(1);
            end
        end else if (drn_emit) begin
            n_pend = r_pend - ckum_pkg::t_pend'(1);
        end
        if (emit) begin
            if (ocol_last) begin
                n_ocol = '0;
                n_orow = orow_last ? '0 : r_orow + ckum_pkg::t_row'(1);
            end else begin
                n_ocol = r_ocol + ckum_pkg::t_col'(1);
            end
        end
        if (restart) begin
            n_col  = '0;
            n_row  = '0;
            n_pend = '0;
            n_ocol = '0;
            n_orow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
        end
    end

    // Line stores: the first delays one row, the second one more row.
    // Drains read pending pixels of the last row back out of the first store.
    assign drain_addr   = ckum_pkg::t_col'(ckum_pkg::t_pend'(w_eff) - r_pend);
    assign ram1_rd_en   = pix_take | (drn_emit & ~pend_full);
    assign ram1_rd_addr = pix_take ? r_col : drain_addr;

    ckum_ram #(
        .WIDTH ($bits(ckum_pkg::t_rgb)),
        .DEPTH (ckum_pkg::MAX_WIDTH)
    ) u_row_older (
        .i_clk     (i_clk),
        .i_wr_en   (pix_take),
        .i_wr_addr (r_col),
        .i_wr_data (in_px),
        .i_rd_en   (ram1_rd_en),
        .i_rd_addr (ram1_rd_addr),
        .o_rd_data (ram1_rd)
    );

    ckum_ram #(
        .WIDTH ($bits(ckum_pkg::t_rgb)),
        .DEPTH (ckum_pkg::MAX_WIDTH)
    ) u_row_newer (
        .i_clk     (i_clk),
        .i_wr_en   (pix_take),
        .i_wr_addr (r_prev_col),
        .i_wr_data (a_val),
        .i_rd_en   (pix_take),
        .i_rd_addr (r_col),
        .o_rd_data (ram2_rd)
    );

    // Keep the pixel one row back alive across drain reads of the first store
    assign a_val = r_a_fresh ? ram1_rd : r_a_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_fresh <= 1'b0;
        end else begin
            r_a_fresh <= pix_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hold <= a_val;
    end

    // Shift the cross window on every pixel word
    always_ff @(posedge i_clk) begin
        if (pix_take) begin
            r_last     <= in_px;
            r_dn       <= r_last;
            r_c        <= a_val;
            r_l        <= r_c;
            r_up       <= ram2_rd;
            r_prev_col <= r_col;
        end
    end

    // Compute stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_inner <= out_inner;
            r_s1_done  <= out_done;
            if (pix_emit) begin
                r_s1_src <= ckum_pkg::SRC_WIN;
            end else if (pend_full) begin
                r_s1_src <= ckum_pkg::SRC_HOLD;
            end else begin
                r_s1_src <= ckum_pkg::SRC_RD;
            end
        end
    end

    // Assemble the window for the compute stage
    always_comb begin
        s1_win.up    = r_up;
        s1_win.left  = r_l;
        s1_win.right = ram1_rd;
        s1_win.down  = r_dn;
        case (r_s1_src)
            ckum_pkg::SRC_WIN:  s1_win.center = r_c;
            ckum_pkg::SRC_RD:   s1_win.center = ram1_rd;
            ckum_pkg::SRC_HOLD: s1_win.center = a_val;
            default:            s1_win.center = r_c;
        endcase
    end

    ckum_sharpen u_sharpen (
        .i_win   (s1_win),
        .i_gain  (r_gain),
        .i_inner (r_s1_inner),
        .o_px    (s1_px)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_px   <= s1_px;
            r_o_done <= r_s1_done;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.out_red    = r_o_px[0];
    assign o_res.out_green  = r_o_px[1];
    assign o_res.out_blue   = r_o_px[2];
    assign o_res.frame_done = r_o_done;

endmodule

FILE: sv/ckum_ram.sv
module ckum_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and read the old word on a clash
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/ckum_sharpen.sv
module ckum_sharpen (
    input  ckum_pkg::t_win  i_win,
    input  ckum_pkg::t_gain i_gain,
    input  logic            i_inner,
    output ckum_pkg::t_rgb  o_px
);

    // One channel: centre + (4*centre - cross sum) * gain / 1024, clamped to 0..255
    function automatic ckum_pkg::t_chan sharpen_chan(
        input ckum_pkg::t_chan c,
        input ckum_pkg::t_chan u,
        input ckum_pkg::t_chan d,
        input ckum_pkg::t_chan l,
        input ckum_pkg::t_chan r,
        input ckum_pkg::t_gain g
    );
        ckum_pkg::t_sum  sum;
        ckum_pkg::t_diff diff;
        ckum_pkg::t_prod prod;
        ckum_pkg::t_acc  acc;
        ckum_pkg::t_chan res;
        sum  = ckum_pkg::t_sum'(u) + ckum_pkg::t_sum'(d)
             + ckum_pkg::t_sum'(l) + ckum_pkg::t_sum'(r);
        diff = ckum_pkg::t_diff'({c, 2'b00}) - ckum_pkg::t_diff'(sum);
        prod = ckum_pkg::t_prod'(diff) * ckum_pkg::t_prod'({1'b0, g});
        acc  = ckum_pkg::t_acc'(prod)
             + ckum_pkg::t_acc'({c, {ckum_pkg::FRAC_W{1'b0}}});
        if (acc[ckum_pkg::ACC_W-1]) begin
            res = '0;
        end else if (|acc[ckum_pkg::ACC_W-2:ckum_pkg::FRAC_W+ckum_pkg::CH_W]) begin
            res = '1;
        end else begin
            res = acc[ckum_pkg::FRAC_W+ckum_pkg::CH_W-1:ckum_pkg::FRAC_W];
        end
        return res;
    endfunction

    // Sharpen inner pixels per channel, pass border pixels through
    always_comb begin
        for (int k = 0; k < ckum_pkg::CH_N; k++) begin
            if (i_inner) begin
                o_px[k] = sharpen_chan(i_win.center[k], i_win.up[k], i_win.down[k],
                                       i_win.left[k], i_win.right[k], i_gain);
            end else begin
                o_px[k] = i_win.center[k];
            end
        end
    end

endmodule

FILE: verif/cross_kernel_unsharp_mask_test.sv
`timescale 1ns / 100ps

module cross_kernel_unsharp_mask_test;
    import ckum_pkg::*;

    localparam int       STALL_LIMIT   = 1000;
    localparam int       RANDOM_WORDS  = 1100;
    localparam int       WIDE_PIXELS   = 200;
    localparam int       HIST_DEPTH    = 8192;
    localparam int       SETTLE_CYCLES = 8;
    localparam int       MAX_GAP       = 17;
    localparam t_cfg_idx CFG_SPARE     = 2'd3;

    typedef struct packed {
        t_rgb px;
        logic frame_done;
    } t_sharp_px;

    // Tracks the pixel stream and works out every output pixel it releases
    class unsharp_stream;
        t_gain     gain;
        t_fw       width_reg;
        t_fh       height_reg;
        t_rgb      history [HIST_DEPTH];
        int        seq;
        int        pending;
        int        in_col;
        int        in_row;
        int        out_col;
        int        out_row;
        t_sharp_px due_pixels [$];
        int        checked;
        int        errors;

        function new();
            foreach (history[i]) history[i] = '0;
            gain       = GAIN_RESET;
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            checked    = 0;
            errors     = 0;
            restart();
        endfunction

        function int eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return int'(height_reg);
        endfunction

        function int in_offset();
            return in_row * eff_w() + in_col;
        endfunction

        // Geometry change drops whatever is still pending
        function void restart();
            seq     = 0;
            pending = 0;
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void note_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_GAIN: begin
                    gain = data[GAIN_W-1:0];
                end
                CFG_WIDTH: begin
                    width_reg = data[FW_W-1:0];
                    restart();
                end
                CFG_HEIGHT: begin
                    height_reg = data[FH_W-1:0];
                    restart();
                end
                default: begin
                end
            endcase
        endfunction

        // centre + (4*centre - cross sum) * gain, in 1/1024 units, truncated and clamped
        function int sharpen_chan(int c, int u, int d, int l, int r);
            int acc;
            acc = 1024 * c + (4 * c - (u + d + l + r)) * int'(gain);
            if (acc < 0) return 0;
            acc = acc >> 10;
            return (acc > 255) ? 255 : acc;
        endfunction

        function void release_pixel(int e);
            int        w;
            int        h;
            t_rgb      ctr;
            t_rgb      up;
            t_rgb      dn;
            t_rgb      lf;
            t_rgb      rt;
            t_sharp_px item;
            w = eff_w();
            h = eff_h();
            ctr = history[e % HIST_DEPTH];
            item.px = ctr;
            // Sharpen inner pixels only; borders pass straight through
            if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
                up = history[(e - w) % HIST_DEPTH];
                dn = history[(e + w) % HIST_DEPTH];
                lf = history[(e - 1) % HIST_DEPTH];
                rt = history[(e + 1) % HIST_DEPTH];
                for (int k = 0; k < CH_N; k++) begin
                    item.px[k] = t_chan'(sharpen_chan(ctr[k], up[k], dn[k], lf[k], rt[k]));
                end
            end
            item.frame_done = (out_row + 1 == h && out_col + 1 == w);
            due_pixels.push_back(item);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
        endfunction

        // Returns 1 when the word releases an output pixel
        function bit note_word(logic op, t_rgb px);
            int w;
            int h;
            w = eff_w();
            h = eff_h();
            if (op == OP_PIXEL) begin
                history[seq % HIST_DEPTH] = px;
                seq++;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= h) in_row = 0;
                end
                pending++;
                if (pending > w + 1) begin
                    release_pixel(seq - pending);
                    pending = w + 1;
                    return 1'b1;
                end
                return 1'b0;
            end
            // Drain only flushes once the input side sits at a frame start
            if (in_col == 0 && in_row == 0 && pending > 0) begin
                release_pixel(seq - pending);
                pending--;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_pixel(t_rgb got, logic done);
            t_sharp_px want;
            checked++;
            if (due_pixels.size() == 0) begin
                if (errors < 10)
                    $display("ERROR: output %0d arrived with none due: r %0d g %0d b %0d done %0d",
                             checked, got[0], got[1], got[2], done);
                errors++;
                return;
            end
            want = due_pixels.pop_front();
            if (got[0] !== want.px[0] || got[1] !== want.px[1] || got[2] !== want.px[2] ||
                done !== want.frame_done) begin
                if (errors < 10) begin
                    $display("ERROR: output %0d expected r %0d g %0d b %0d done %0d", checked,
                             want.px[0], want.px[1], want.px[2], want.frame_done);
                    $display("       got                r %0d g %0d b %0d done %0d",
                             got[0], got[1], got[2], done);
                end
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    ckum_pix_if    pix ();
    ckum_res_if    res ();
    ckum_cfg_if    cfg ();
    unsharp_stream board;
    bit            pix_calm;
    bit            res_calm;
    int            quiet_cycles;
    int            pixel_words;
    int            drain_words;
    int            counted_words;
    int            setting_count;

    cross_kernel_unsharp_mask dut (
        .i_clk,
        .i_rst_n,
        .i_pix (pix),
        .o_res (res),
        .i_cfg (cfg)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Mostly random channels, with a fair share of the extremes
    function automatic t_rgb random_px();
        t_rgb px;
        for (int k = 0; k < CH_N; k++) begin
            case ($urandom_range(0, 5))
                0:       px[k] = 8'd0;
                1:       px[k] = 8'd255;
                default: px[k] = t_chan'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        board.note_reg(idx, data);
    endtask

    task automatic configure(t_cfg_data gain_data, t_cfg_data width_data,
                             t_cfg_data height_data, bit geometry, bit spare);
        write_reg(CFG_GAIN, gain_data);
        if (spare) write_reg(CFG_SPARE, t_cfg_data'($urandom()));
        if (geometry) begin
            write_reg(CFG_WIDTH, width_data);
            write_reg(CFG_HEIGHT, height_data);
        end
        cfg.valid <= 1'b0;
        setting_count++;
    endtask

    // Hold valid across back-to-back words; lower it only for a gap
    task automatic send_word(logic op, t_rgb px);
        int gap;
        bit emitted;
        gap = draw_gap(pix_calm);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.operation <= op;
        pix.in_red    <= px[0];
        pix.in_green  <= px[1];
        pix.in_blue   <= px[2];
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        emitted = board.note_word(op, px);
        if (emitted || op == OP_PIXEL) counted_words++;
        if (op == OP_PIXEL) pixel_words++;
        else drain_words++;
    endtask

    task automatic wait_idle();
        while (board.due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_words();
        pix.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic run_phase(int pixels, bit flush, int noise_pct);
        int tail;
        for (int i = 0; i < pixels; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(OP_DRAIN, random_px());
            send_word(OP_PIXEL, random_px());
        end
        tail = flush ? board.pending + int'($urandom_range(0, 2)) : int'($urandom_range(0, 2));
        repeat (tail) send_word(OP_DRAIN, random_px());
        finish_words();
    endtask

    // Result side: random stalls, check every word taken
    initial begin : result_sink
        int gap;
        res.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = draw_gap(res_calm);
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (res.valid !== 1'b1);
            board.check_pixel({res.out_blue, res.out_green, res.out_red}, res.frame_done);
        end
    end

    // Abort when no word has moved on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("cross_kernel_unsharp_mask: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_rgb      px;
        t_cfg_data gain_data;
        t_cfg_data width_data;
        t_cfg_data height_data;
        int        phase;
        int        frames;
        int        count;
        bit        restart;
        bit        flush;

        board         = new();
        quiet_cycles  = 0;
        pixel_words   = 0;
        drain_words   = 0;
        counted_words = 0;
        setting_count = 0;
        pix_calm      = 1'b0;
        res_calm      = 1'b0;
        pix.valid     <= 1'b0;
        pix.operation <= OP_PIXEL;
        pix.in_red    <= '0;
        pix.in_green  <= '0;
        pix.in_blue   <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= CFG_GAIN;
        cfg.data      <= '0;
        i_rst_n       <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: a partial frame, so the drain does nothing
        send_word(OP_PIXEL, {3{8'hFF}});
        send_word(OP_PIXEL, '0);
        send_word(OP_DRAIN, '0);
        finish_words();

        // 4x4 frame at gain 435: checkerboards drive the clamps both ways
        configure(t_cfg_data'(435), t_cfg_data'(4), t_cfg_data'(4), 1'b1, 1'b0);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                px[0] = ((r + c) % 2 == 1) ? 8'd255 : 8'd0;
                px[1] = ((r + c) % 2 == 1) ? 8'd0 : 8'd255;
                px[2] = t_chan'((r * 4 + c) * 17);
                send_word(OP_PIXEL, px);
            end
        end
        repeat (6) send_word(OP_DRAIN, random_px());
        finish_words();

        // Random phases: fixed corner settings first, then free draws
        counted_words = 0;
        phase = 0;
        while (counted_words < RANDOM_WORDS) begin
            restart = (phase < 8) || ($urandom_range(0, 2) != 0);
            case (phase)
                0: begin gain_data = 0;   width_data = 5; height_data = 4;    end
                1: begin gain_data = 435; width_data = 3; height_data = 3;    end
                2: begin gain_data = 511; width_data = 1; height_data = 1;    end
                3: begin gain_data = 1;   width_data = 0; height_data = 6;    end
                4: begin
                    gain_data = t_cfg_data'($urandom_range(0, 435));
                    width_data = 7; height_data = 0;
                end
                5: begin
                    gain_data = t_cfg_data'($urandom_range(0, 435));
                    width_data = 2; height_data = 4096;
                end
                6: begin
                    gain_data = t_cfg_data'($urandom_range(0, 435));
                    width_data = 9; height_data = 8191;
                end
                7: begin
                    gain_data = t_cfg_data'($urandom_range(436, 511));
                    width_data = 40; height_data = 8;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       gain_data = 0;
                        1:       gain_data = 435;
                        2:       gain_data = t_cfg_data'($urandom_range(436, 511));
                        default: gain_data = t_cfg_data'($urandom_range(1, 434));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       width_data = 0;
                        1:       width_data = 1;
                        2:       width_data = 2;
                        3:       width_data = 3;
                        default: width_data = t_cfg_data'($urandom_range(4, 40));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       height_data = 0;
                        1:       height_data = 1;
                        2:       height_data = 2;
                        3:       height_data = t_cfg_data'($urandom_range(4097, 8191));
                        4:       height_data = 4096;
                        default: height_data = t_cfg_data'($urandom_range(3, 8));
                    endcase
                end
            endcase
            // Stray upper bits beyond the gain and width register widths must be dropped
            if ($urandom_range(0, 3) == 0) gain_data[12:9] = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0) width_data[12] = 1'b1;
            pix_calm = ($urandom_range(0, 3) == 0);
            res_calm = ($urandom_range(0, 3) == 0);
            configure(gain_data, width_data, height_data, restart,
                      (phase == 3) || ($urandom_range(0, 7) == 0));
            frames = $urandom_range(1, 3);
            count = frames * board.eff_w() * board.eff_h() - board.in_offset();
            flush = ($urandom_range(0, 3) != 0);
            if (count > 400) begin
                count = $urandom_range(60, 400);
                flush = 1'b0;
            end else if (!flush) begin
                count = $urandom_range(1, count);
            end
            run_phase(count, flush, 6);
            phase++;
        end

        // Width above range and height zero: a partial row releases nothing
        pix_calm = ($urandom_range(0, 1) == 0);
        res_calm = ($urandom_range(0, 1) == 0);
        configure(t_cfg_data'(300), t_cfg_data'(4095), t_cfg_data'(0), 1'b1, 1'b0);
        run_phase(WIDE_PIXELS, 1'b0, 2);

        $display("Ran %0d pixel words and %0d drain words over %0d register settings,",
                 pixel_words, drain_words, setting_count);
        $display("checking %0d output pixels with %0d mismatched.", board.checked, board.errors);
        if (board.errors == 0 && board.due_pixels.size() == 0) begin
            $display("cross_kernel_unsharp_mask: match");
        end else begin
            $display("cross_kernel_unsharp_mask: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ckum_pkg.sv
sv/ckum_if.sv
sv/ckum_ram.sv
sv/ckum_sharpen.sv
sv/cross_kernel_unsharp_mask.sv
verif/cross_kernel_unsharp_mask_test.sv
